// ===== hdl/gcl_pkg.sv =====
// Shared definitions for the GCD / LCM unit.
// Holds the default width and the command and status structs between
// the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package gcl_pkg;

    localparam int unsigned GCL_WIDTH = 16;

    // Commands issued by the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the operands of a new item
        logic gcd_step;  // one binary GCD reduction step
        logic div_init;  // latch the GCD and start dividing operand a by it
        logic div_step;  // one restoring division step
        logic mul;       // form the LCM from quotient and operand b
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status returned by the datapath.
    typedef struct packed {
        logic gcd_done;  // one working operand has reached zero
        logic div_done;  // all quotient bits are formed
    } t_stat;

endpackage

// ===== hdl/gcl_ctrl.sv =====
// Controller state machine of the GCD / LCM unit.
// Sequences load, GCD, divide, multiply and output; uses gcl_pkg.
`timescale 1ns / 1ps

module gcl_ctrl
    import gcl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/gcl_dpath.sv =====
// Datapath of the GCD / LCM unit: binary GCD, restoring divider,
// multiplier and output register. Uses gcl_pkg for the command structs.
`timescale 1ns / 1ps

module gcl_dpath
    import gcl_pkg::*;
#(
    parameter int unsigned WIDTH = GCL_WIDTH
) (
    input  logic               i_clk,
    input  logic [WIDTH-1:0]   i_operand_a,
    input  logic [WIDTH-1:0]   i_operand_b,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [WIDTH-1:0]   o_gcd_value,
    output logic [2*WIDTH-1:0] o_lcm_value
);

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]   r_a, r_b, r_oa, r_ob;
    logic [CW-1:0]      r_k;
    logic [WIDTH-1:0]   r_g, r_rem, r_quo;
    logic [CW-1:0]      r_cnt;
    logic [2*WIDTH-1:0] r_lcm;
    logic [WIDTH-1:0]   r_gcd_out;
    logic [2*WIDTH-1:0] r_lcm_out;

    logic [WIDTH-1:0]   w_gcd;
    logic [WIDTH:0]     w_rem_sh;
    logic [WIDTH:0]     w_rem_sub;
    logic               w_q_bit;

    // Once one operand is zero the other, scaled back by the common
    // power of two, is the divisor.
    assign w_gcd = (r_a | r_b) << r_k;

    assign w_rem_sh  = {r_rem, r_quo[WIDTH-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_g};
    assign w_q_bit   = !w_rem_sub[WIDTH];

    assign o_stat.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_stat.div_done = (r_cnt == CW'(WIDTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
            r_oa <= i_operand_a;
            r_ob <= i_operand_b;
            r_k  <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                // Difference of two odd values is even, so halve it now.
                r_a <= (r_a - r_b) >> 1;
            end else begin
                r_b <= (r_b - r_a) >> 1;
            end
        end

        if (i_cmd.div_init) begin
            r_g   <= w_gcd;
            r_rem <= '0;
            r_quo <= r_oa;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_q_bit ? w_rem_sub[WIDTH-1:0] : w_rem_sh[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_q_bit};
            r_cnt <= r_cnt + 1'b1;
        end

        if (i_cmd.mul) begin
            if ((r_oa == '0) || (r_ob == '0)) begin
                r_lcm <= '0;
            end else begin
                r_lcm <= (2*WIDTH)'(r_quo) * (2*WIDTH)'(r_ob);
            end
        end

        if (i_cmd.out_load) begin
            r_gcd_out <= r_g;
            r_lcm_out <= r_lcm;
        end
    end

    assign o_gcd_value = r_gcd_out;
    assign o_lcm_value = r_lcm_out;

endmodule

// ===== hdl/gcd_lcm_unit.sv =====
// GCD / LCM unit, top level. Each accepted item goes through the GCD steps
// with the final check, the divider steps, one multiply and one output load.
// One item is in work at a time: a new item is taken only after the last one
// has moved into the output register. That register lets the next item in while
// a result waits, and a stalled result delays only the next load. Reset
// (synchronous, active low) clears the controller.
`timescale 1ns / 1ps

module gcd_lcm_unit
    import gcl_pkg::*;
#(
    parameter int unsigned WIDTH = GCL_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [WIDTH-1:0]   i_operand_a,
    input  logic [WIDTH-1:0]   i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WIDTH-1:0]   o_gcd_value,
    output logic [2*WIDTH-1:0] o_lcm_value
);

    // The controller walks each item through its phases; the datapath
    // holds all operand, divider and result registers.
    t_cmd  w_cmd;
    t_stat w_stat;

    // An item is accepted only while the controller is idle. The input
    // stall is high for the whole time an item is being worked on.
    gcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The GCD is found by the binary method, the LCM as a / gcd * b with a
    // restoring divider and a single registered multiply. Zero operands
    // give the other operand as GCD and zero as LCM.
    gcl_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_gcd_value (o_gcd_value),
        .o_lcm_value (o_lcm_value)
    );

endmodule
